// ===== rtl/dnsq_pkg.sv =====
// Shared types, constants and helpers for the DNS query builder.
package dnsq_pkg;

  localparam int LABEL_MAX = 63;
  localparam int LBL_W     = 6;               // holds 0..LABEL_MAX
  localparam int RAM_DEPTH = 2 * (2 ** LBL_W); // two label banks
  localparam int RAM_AW    = LBL_W + 1;
  localparam int HDR_LEN   = 12;
  localparam int TAIL_LEN  = 5;
  localparam int CNT_W     = 7;               // bytes per request, up to 81
  localparam int FQ_AW     = 1;
  localparam int FQ_DEPTH  = 2 ** FQ_AW;

  localparam logic [7:0] DOT_CHAR = 8'h2E;

  localparam logic [1:0] FAM_A    = 2'd0;
  localparam logic [1:0] FAM_AAAA = 2'd1;

  localparam logic [7:0] QTYPE_A    = 8'd1;
  localparam logic [7:0] QTYPE_AAAA = 8'd28;
  localparam logic [7:0] QTYPE_ANY  = 8'd255;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SMALL = 2'd1;
  localparam logic [1:0] ST_LONG  = 2'd2;

  localparam logic CFG_FAMILY = 1'b0;
  localparam logic CFG_MAXLEN = 1'b1;

  localparam logic [15:0] MAXLEN_RESET = 16'd512;

  // one queued job for the byte sequencer
  typedef struct packed {
    logic             hdr;     // send the 12-byte header first
    logic             label;   // send length byte and buffered label
    logic             fin;     // send terminator, QTYPE, QCLASS and close
    logic [LBL_W-1:0] len;
    logic             bank;
    logic [1:0]       status;
    logic [7:0]       qtype;
  } cmd_t;

  typedef struct packed {
    logic              we;
    logic [RAM_AW-1:0] addr;
    logic [7:0]        data;
  } ram_wr_t;

  typedef struct packed {
    logic              re;
    logic [RAM_AW-1:0] addr;
  } ram_rd_t;

  // ID 0, RD set, QDCOUNT 1
  function automatic logic [7:0] hdr_byte(input logic [LBL_W-1:0] idx);
    hdr_byte = (idx == LBL_W'(2) || idx == LBL_W'(5)) ? 8'd1 : 8'd0;
  endfunction

  // zero root label, QTYPE, QCLASS 1
  function automatic logic [7:0] tail_byte(input logic [LBL_W-1:0] idx,
                                           input logic [7:0] qtype);
    logic [7:0] b;
    b = 8'd0;
    if (idx == LBL_W'(2)) b = qtype;
    else if (idx == LBL_W'(4)) b = 8'd1;
    tail_byte = b;
  endfunction

endpackage

// ===== rtl/dnsq_if.sv =====
// Handshake channels of the DNS query builder.
interface dnsq_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] character;

  modport source(output valid, action, character, input ready);
  modport sink(input valid, action, character, output ready);
endinterface

interface dnsq_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] first_byte;
  logic [7:0] second_byte;
  logic       second_valid;
  logic       run_last;
  logic       query_end;
  logic [1:0] status;

  modport source(output valid, first_byte, second_byte, second_valid, run_last,
                 query_end, status, input ready);
  modport sink(input valid, first_byte, second_byte, second_valid, run_last,
               query_end, status, output ready);
endinterface

// ===== rtl/dnsq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dnsq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

// ===== rtl/dnsq_front.sv =====
// Front end: takes characters, buffers labels, keeps query state, queues jobs.
module dnsq_front (
  input  logic             clk,
  input  logic             rst_n,
  dnsq_in_if.sink          in_ch,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [15:0]      cfg_wdata,
  input  logic             fifo_full,
  output logic             push,
  output dnsq_pkg::cmd_t   push_cmd,
  output dnsq_pkg::ram_wr_t ram_wr,
  input  logic             label_done
);
  import dnsq_pkg::*;

  logic [1:0]       family_r;
  logic [15:0]      max_len_r;
  logic [LBL_W-1:0] label_count_r, label_count_nxt;
  logic             started_r, started_nxt;
  logic [15:0]      name_len_r, name_len_nxt;
  logic             ovf_r, ovf_nxt;
  logic             wbank_r, wbank_nxt;
  logic             busy_r, busy_nxt;

  logic             is_end, is_dot, is_label, need_push, acc, room;
  logic [16:0]      msg_len;
  logic [7:0]       qtype;
  logic [1:0]       status;

  always_comb begin
    is_end    = in_ch.action;
    is_dot    = !is_end && (in_ch.character == DOT_CHAR);
    is_label  = is_end || is_dot;
    need_push = !started_r || is_label;
    // a new label flush waits until the sequencer has read out the last one
    in_ch.ready = !(need_push && fifo_full) && !(is_label && busy_r);
    acc       = in_ch.valid && in_ch.ready;
    push      = acc && need_push;
    room      = label_count_r < LBL_W'(LABEL_MAX);

    msg_len = {1'b0, name_len_r} + 17'(HDR_LEN + 1 + TAIL_LEN);
    if (msg_len > {1'b0, max_len_r}) status = ST_SMALL;
    else if (ovf_r)                  status = ST_LONG;
    else                             status = ST_OK;

    case (family_r)
      FAM_A:    qtype = QTYPE_A;
      FAM_AAAA: qtype = QTYPE_AAAA;
      default:  qtype = QTYPE_ANY;
    endcase

    push_cmd.hdr    = !started_r;
    push_cmd.label  = is_label;
    push_cmd.fin    = is_end;
    push_cmd.len    = label_count_r;
    push_cmd.bank   = wbank_r;
    push_cmd.status = status;
    push_cmd.qtype  = qtype;

    ram_wr.we   = acc && !is_label && room;
    ram_wr.addr = {wbank_r, label_count_r};
    ram_wr.data = in_ch.character;

    label_count_nxt = label_count_r;
    started_nxt     = started_r;
    name_len_nxt    = name_len_r;
    ovf_nxt         = ovf_r;
    wbank_nxt       = wbank_r;
    busy_nxt        = label_done ? 1'b0 : busy_r;

    if (acc) begin
      if (is_end) begin
        label_count_nxt = '0;
        started_nxt     = 1'b0;
        name_len_nxt    = '0;
        ovf_nxt         = 1'b0;
        wbank_nxt       = !wbank_r;
        busy_nxt        = 1'b1;
      end else begin
        started_nxt = 1'b1;
        if (name_len_r != 16'hFFFF) name_len_nxt = name_len_r + 16'd1;
        if (is_dot) begin
          label_count_nxt = '0;
          wbank_nxt       = !wbank_r;
          busy_nxt        = 1'b1;
        end else if (room) begin
          label_count_nxt = label_count_r + LBL_W'(1);
        end else begin
          ovf_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      family_r      <= FAM_A;
      max_len_r     <= MAXLEN_RESET;
      label_count_r <= '0;
      started_r     <= 1'b0;
      name_len_r    <= '0;
      ovf_r         <= 1'b0;
      wbank_r       <= 1'b0;
      busy_r        <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == CFG_FAMILY) family_r  <= cfg_wdata[1:0];
      if (cfg_we && cfg_index == CFG_MAXLEN) max_len_r <= cfg_wdata;
      label_count_r <= label_count_nxt;
      started_r     <= started_nxt;
      name_len_r    <= name_len_nxt;
      ovf_r         <= ovf_nxt;
      wbank_r       <= wbank_nxt;
      busy_r        <= busy_nxt;
    end
  end
endmodule

// ===== rtl/dnsq_cmd_fifo.sv =====
// Two-entry job queue between the front end and the byte sequencer.
module dnsq_cmd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  dnsq_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output dnsq_pkg::cmd_t head
);
  import dnsq_pkg::*;

  cmd_t             mem_r [FQ_DEPTH];
  logic [FQ_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FQ_AW:0]   count_r;

  assign full  = count_r == (FQ_AW + 1)'(FQ_DEPTH);
  assign empty = count_r == '0;
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + FQ_AW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + FQ_AW'(1);
      case ({push, pop})
        2'b10:   count_r <= count_r + (FQ_AW + 1)'(1);
        2'b01:   count_r <= count_r - (FQ_AW + 1)'(1);
        default: count_r <= count_r;
      endcase
    end
  end
endmodule

// ===== rtl/dnsq_back.sv =====
// Back end: byte sequencer that walks a job and packs bytes into pairs.
module dnsq_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            fifo_empty,
  input  dnsq_pkg::cmd_t  head,
  output logic            pop,
  output dnsq_pkg::ram_rd_t ram_rd,
  input  logic [7:0]      ram_rdata,
  output logic            label_done,
  dnsq_out_if.source      out_ch
);
  import dnsq_pkg::*;

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_HDR  = 5'b00010,
    PH_LEN  = 5'b00100,
    PH_LAB  = 5'b01000,
    PH_TAIL = 5'b10000
  } phase_t;

  phase_t           phase_r, phase_nxt;
  cmd_t             cmd_r;
  logic [LBL_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic             have_first_r, have_first_nxt;
  logic [7:0]       first_r, first_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       ob1_r, ob1_nxt, ob2_r, ob2_nxt;
  logic             osv_r, osv_nxt, olast_r, olast_nxt, oend_r, oend_nxt;
  logic [1:0]       ost_r, ost_nxt;

  logic             active, emit, can_emit, advance, final_byte;
  logic [7:0]       cur;
  logic [CNT_W-1:0] total;

  always_comb begin
    total = (head.hdr ? CNT_W'(HDR_LEN) : '0)
          + (head.label ? CNT_W'(head.len) + CNT_W'(1) : '0)
          + (head.fin ? CNT_W'(TAIL_LEN) : '0);

    case (phase_r)
      PH_HDR:  cur = hdr_byte(idx_r);
      PH_LEN:  cur = 8'(cmd_r.len);
      PH_LAB:  cur = ram_rdata;
      PH_TAIL: cur = tail_byte(idx_r, cmd_r.qtype);
      default: cur = 8'd0;
    endcase

    active     = phase_r != PH_IDLE;
    final_byte = rem_r == CNT_W'(1);
    emit       = have_first_r || (cmd_r.fin && final_byte);
    can_emit   = !out_valid_r || out_ch.ready;
    advance    = active && (!emit || can_emit);
    pop        = (phase_r == PH_IDLE) && !fifo_empty;
    label_done = advance && final_byte && cmd_r.label;

    // read one label byte ahead; held data stays put while stalled
    ram_rd.re   = advance && (phase_r == PH_LEN || phase_r == PH_LAB);
    ram_rd.addr = {cmd_r.bank, (phase_r == PH_LEN) ? LBL_W'(0) : idx_r + LBL_W'(1)};

    phase_nxt      = phase_r;
    idx_nxt        = idx_r;
    rem_nxt        = rem_r;
    have_first_nxt = have_first_r;
    first_nxt      = first_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    ob1_nxt        = ob1_r;
    ob2_nxt        = ob2_r;
    osv_nxt        = osv_r;
    olast_nxt      = olast_r;
    oend_nxt       = oend_r;
    ost_nxt        = ost_r;

    if (pop) begin
      phase_nxt = head.hdr ? PH_HDR : PH_LEN;
      idx_nxt   = '0;
      rem_nxt   = total;
    end

    if (advance) begin
      rem_nxt = rem_r - CNT_W'(1);
      idx_nxt = idx_r + LBL_W'(1);
      if (emit) begin
        out_valid_nxt  = 1'b1;
        have_first_nxt = 1'b0;
        ob1_nxt        = have_first_r ? first_r : cur;
        ob2_nxt        = have_first_r ? cur : 8'd0;
        osv_nxt        = have_first_r;
        // odd leftover of a non-final job waits for the next job
        olast_nxt      = cmd_r.fin ? final_byte : (rem_r <= CNT_W'(2));
        oend_nxt       = cmd_r.fin && final_byte;
        ost_nxt        = (cmd_r.fin && final_byte) ? cmd_r.status : ST_OK;
      end else begin
        have_first_nxt = 1'b1;
        first_nxt      = cur;
      end

      if (final_byte) begin
        phase_nxt = PH_IDLE;
      end else begin
        case (phase_r)
          PH_HDR: begin
            if (idx_r == LBL_W'(HDR_LEN - 1)) begin
              idx_nxt   = '0;
              phase_nxt = cmd_r.label ? PH_LEN : PH_TAIL;
            end
          end
          PH_LEN: begin
            idx_nxt   = '0;
            phase_nxt = (cmd_r.len == '0) ? PH_TAIL : PH_LAB;
          end
          PH_LAB: begin
            if (idx_r == cmd_r.len - LBL_W'(1)) begin
              idx_nxt   = '0;
              phase_nxt = PH_TAIL;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd_r <= head;
    end
    idx_r   <= idx_nxt;
    rem_r   <= rem_nxt;
    first_r <= first_nxt;
    ob1_r   <= ob1_nxt;
    ob2_r   <= ob2_nxt;
    osv_r   <= osv_nxt;
    olast_r <= olast_nxt;
    oend_r  <= oend_nxt;
    ost_r   <= ost_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      have_first_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      have_first_r <= have_first_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.first_byte   = ob1_r;
  assign out_ch.second_byte  = ob2_r;
  assign out_ch.second_valid = osv_r;
  assign out_ch.run_last     = olast_r;
  assign out_ch.query_end    = oend_r;
  assign out_ch.status       = ost_r;
endmodule

// ===== rtl/dns_query_builder.sv =====
// Top level of the DNS query builder: front end, job queue, label RAM, sequencer.
//
//   channel  dir  handshake          payload
//   in_ch    in   valid/ready        action, character
//   out_ch   out  valid/ready        first_byte, second_byte, second_valid,
//                                    run_last, query_end, status
//   cfg_*    in   cfg_we, no stall   cfg_index (0 family, 1 max length), cfg_wdata
//
// A plain name character other than the first of a query never waits. A request
// that emits bytes queues a job; the sequencer then produces one message byte
// per cycle while out_ch does not stall, packed in pairs into results (header 6
// results, a label of n characters n+1 bytes); the single RAM read port sets it.
// Reset is synchronous on rst_n; the label RAM needs no clearing.
// A dot or end waits while the previous label is still being read out, and a
// full job queue or a stalled out_ch holds the front end back.
module dns_query_builder (
  input  logic        clk,
  input  logic        rst_n,
  dnsq_in_if.sink     in_ch,
  dnsq_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);
  import dnsq_pkg::*;

  logic       fifo_full, fifo_empty, push, pop, label_done;
  cmd_t       push_cmd, head;
  ram_wr_t    ram_wr;
  ram_rd_t    ram_rd;
  logic [7:0] ram_rdata;

  dnsq_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fifo_full  (fifo_full),
    .push       (push),
    .push_cmd   (push_cmd),
    .ram_wr     (ram_wr),
    .label_done (label_done)
  );

  dnsq_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (fifo_full),
    .pop      (pop),
    .empty    (fifo_empty),
    .head     (head)
  );

  dnsq_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_label_ram (
    .clk   (clk),
    .we    (ram_wr.we),
    .waddr (ram_wr.addr),
    .wdata (ram_wr.data),
    .re    (ram_rd.re),
    .raddr (ram_rd.addr),
    .rdata (ram_rdata)
  );

  dnsq_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .fifo_empty (fifo_empty),
    .head       (head),
    .pop        (pop),
    .ram_rd     (ram_rd),
    .ram_rdata  (ram_rdata),
    .label_done (label_done),
    .out_ch     (out_ch)
  );
endmodule
